@@ rtl/assert_macros.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define HSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram assertion failed");

// Next-cycle implication, checked outside reset.
`define HSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram assertion failed");

`else

`define HSH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hsh_pkg.sv @@
// Shared constants, types and commands of the hue by saturation histogram.
package hsh_pkg;

    localparam int HUE_BINS   = 360;
    localparam int SAT_ROWS   = 10;
    localparam int HIST_DEPTH = HUE_BINS * SAT_ROWS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int COMP_W = 8;
    localparam int BIN_W  = 8;
    localparam int HUE_W  = 9;
    localparam int ROW_W  = 4;
    localparam int CMD_W  = 2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Divider sizing: quotient below 2**DIV_QUO_W, divisor up to 2*255.
    localparam int DIV_QUO_W  = 9;
    localparam int DIV_DEN_W  = 9;
    localparam int DIV_NUM_W  = DIV_DEN_W + DIV_QUO_W - 1;
    localparam int DIV_STEP_W = $clog2(DIV_QUO_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage

@@ rtl/hsh_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module hsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents of the addressed entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hsh_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module hsh_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hsh_pkg::t_div_req              i_req,
    output logic                           o_done,
    output logic [hsh_pkg::DIV_QUO_W-1:0] o_quo
);
    import hsh_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_steps;
    logic [DIV_NUM_W-1:0]  r_rem;
    logic [DIV_NUM_W-1:0]  r_den;
    logic [DIV_QUO_W-1:0]  r_quo;
    logic                  w_ge;

    // The divisor starts aligned to the top quotient bit and moves down.
    assign w_ge = (r_rem >= r_den);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_steps == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: one compare and subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= i_req.num;
            r_den   <= {i_req.den, {(DIV_QUO_W-1){1'b0}}};
            r_quo   <= '0;
            r_steps <= DIV_STEP_W'(DIV_QUO_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_den;
            end
            r_quo   <= {r_quo[DIV_QUO_W-2:0], w_ge};
            r_den   <= r_den >> 1;
            r_steps <= r_steps - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ rtl/hue_saturation_histogram.sv @@
// Hue by saturation histogram of RGB pixels, stored in one synchronous RAM.
// A counted pixel takes prep, both divisions, a RAM read and a write back; an uncounted one
// skips the RAM; an in-range read uses the RAM read, and a clear runs a full clearing pass.
// One word is in work at a time; the next is taken in the cycle after its result is registered,
// and a result still waiting in the output register holds the block in its last step.
// Reset starts a clearing pass, one entry per cycle; no word is taken until it ends.
module hue_saturation_histogram (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red[7:0], green[15:8], blue[23:16], read_hue[32:24], read_row[36:33], zeros
    input  logic [hsh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [hsh_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hue_bin[8:0], sat_row[12:9], counted[13], value_level[21:14],
    // bin_count[29:22], zeros
    output logic [hsh_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    `include "assert_macros.svh"
    import hsh_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    t_state               r_state;
    logic [HIST_AW-1:0]   r_clr_addr;
    logic                 r_clr_reply;
    logic [COMP_W-1:0]    r_red;
    logic [COMP_W-1:0]    r_grn;
    logic [COMP_W-1:0]    r_blu;
    logic [COMP_W-1:0]    r_mx;
    logic [COMP_W-1:0]    r_d;
    logic signed [COMP_W:0] r_diff;
    t_sector              r_sec;
    logic [HIST_AW-1:0]   r_addr;
    logic                 r_is_add;
    logic [HUE_W-1:0]     r_res_hue;
    logic [ROW_W-1:0]     r_res_row;
    logic                 r_res_cnt;
    logic [COMP_W-1:0]    r_res_val;
    logic [BIN_W-1:0]     r_res_bin;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_cmd                 w_cmd;
    logic [HUE_W-1:0]     w_rd_hue;
    logic [ROW_W-1:0]     w_rd_row;
    logic                 w_rd_ok;
    logic [HIST_AW:0]     w_rd_idx;
    logic [COMP_W-1:0]    w_mx;
    logic [COMP_W-1:0]    w_mn;
    t_sector              w_sec;
    logic signed [COMP_W:0] w_diff;
    logic signed [17:0]   w_d_s;
    logic signed [17:0]   w_num_raw;
    logic signed [17:0]   w_num;
    t_div_req             w_hue_req;
    t_div_req             w_sat_req;
    logic                 w_hue_done;
    logic                 w_sat_done;
    logic [DIV_QUO_W-1:0] w_hue_quo;
    logic [DIV_QUO_W-1:0] w_sat_quo;
    logic [ROW_W-1:0]     w_tenths;
    logic [HUE_W-1:0]     w_hue;
    logic [ROW_W-1:0]     w_row;
    logic [HIST_AW:0]     w_add_idx;
    logic                 w_ram_we;
    logic [HIST_AW-1:0]   w_ram_addr;
    logic [BIN_W-1:0]     w_ram_wdata;
    logic [BIN_W-1:0]     w_ram_rdata;
    logic [BIN_W-1:0]     w_bin_inc;
    logic                 w_out_free;

    // Input word fields.
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign w_rd_hue = s_axis_tdata[32:24];
    assign w_rd_row = s_axis_tdata[36:33];
    assign w_rd_ok  = (w_rd_hue < HUE_W'(HUE_BINS)) && (w_rd_row < ROW_W'(SAT_ROWS));
    assign w_rd_idx = (HIST_AW+1)'(w_rd_hue) * (HIST_AW+1)'(SAT_ROWS)
                    + (HIST_AW+1)'(w_rd_row);

    // Largest and smallest component; ties go to red, then green.
    always_comb begin
        w_mn = r_red;
        if (r_grn < w_mn) w_mn = r_grn;
        if (r_blu < w_mn) w_mn = r_blu;
        priority if (r_red >= r_grn && r_red >= r_blu) begin
            w_mx   = r_red;
            w_sec  = SEC_RED;
            w_diff = $signed({1'b0, r_grn}) - $signed({1'b0, r_blu});
        end else if (r_grn >= r_blu) begin
            w_mx   = r_grn;
            w_sec  = SEC_GREEN;
            w_diff = $signed({1'b0, r_blu}) - $signed({1'b0, r_red});
        end else begin
            w_mx   = r_blu;
            w_sec  = SEC_BLUE;
            w_diff = $signed({1'b0, r_red}) - $signed({1'b0, r_grn});
        end
    end

    // Hue numerator: 60*diff plus the sector offset, wrapped up by 360*d.
    assign w_d_s = $signed({10'd0, r_d});
    always_comb begin
        unique case (r_sec)
            SEC_GREEN: w_num_raw = 18'(18'(r_diff) * 18'sd60) + 18'(w_d_s * 18'sd120);
            SEC_BLUE:  w_num_raw = 18'(18'(r_diff) * 18'sd60) + 18'(w_d_s * 18'sd240);
            default:   w_num_raw = 18'(18'(r_diff) * 18'sd60);
        endcase
        w_num = w_num_raw;
        if (w_num_raw[17]) begin
            w_num = w_num_raw + 18'(w_d_s * 18'sd360);
        end
    end

    // Both divisions start together and finish together.
    always_comb begin
        w_hue_req.start = (r_state == ST_DIV_GO);
        w_hue_req.num   = w_num[DIV_NUM_W-1:0];
        w_hue_req.den   = DIV_DEN_W'(r_d);
        w_sat_req.start = (r_state == ST_DIV_GO);
        w_sat_req.num   = DIV_NUM_W'(DIV_NUM_W'(r_d) * DIV_NUM_W'(20) + DIV_NUM_W'(r_mx));
        w_sat_req.den   = {r_mx, 1'b0};
    end

    hsh_div u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_hue_req),
        .o_done  (w_hue_done),
        .o_quo   (w_hue_quo)
    );

    hsh_div u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sat_req),
        .o_done  (w_sat_done),
        .o_quo   (w_sat_quo)
    );

    // Black and gray pixels divide by zero; their hue and tenths are zero.
    assign w_tenths  = (r_mx == '0) ? '0 : w_sat_quo[ROW_W-1:0];
    assign w_hue     = (r_d == '0) ? '0 : w_hue_quo;
    assign w_row     = ROW_W'(SAT_ROWS) - w_tenths;
    assign w_add_idx = (HIST_AW+1)'(w_hue) * (HIST_AW+1)'(SAT_ROWS)
                     + (HIST_AW+1)'(w_row);

    // Histogram RAM port: clearing pass, write back, or read.
    assign w_bin_inc = w_ram_rdata + 1'b1;
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_addr;
        w_ram_wdata = w_bin_inc;
        if (r_state == ST_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_addr  = r_clr_addr;
            w_ram_wdata = '0;
        end else if (r_state == ST_WRITE && r_is_add) begin
            w_ram_we = 1'b1;
        end
    end

    hsh_ram #(
        .WIDTH (BIN_W),
        .DEPTH (HIST_DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Sequencer, work registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register loads from the last step and empties once its word is taken.
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == HIST_AW'(HIST_DEPTH - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_reply ? ST_DONE : ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_res_hue   <= '0;
                        r_res_row   <= '0;
                        r_res_cnt   <= 1'b0;
                        r_res_val   <= '0;
                        r_res_bin   <= '0;
                        r_is_add    <= 1'b0;
                        r_clr_reply <= (w_cmd == CMD_CLEAR);
                        r_red       <= s_axis_tdata[7:0];
                        r_grn       <= s_axis_tdata[15:8];
                        r_blu       <= s_axis_tdata[23:16];
                        r_addr      <= w_rd_idx[HIST_AW-1:0];
                        unique case (w_cmd)
                            CMD_CLEAR: begin
                                r_state <= ST_CLEAR;
                            end
                            CMD_ADD: begin
                                r_state <= ST_PREP;
                            end
                            CMD_READ: begin
                                r_state <= w_rd_ok ? ST_READ : ST_DONE;
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    r_mx    <= w_mx;
                    r_d     <= w_mx - w_mn;
                    r_sec   <= w_sec;
                    r_diff  <= w_diff;
                    r_state <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (w_hue_done) begin
                        r_res_hue <= w_hue;
                        r_res_row <= w_row;
                        r_res_val <= r_mx;
                        r_res_cnt <= (w_tenths != '0);
                        r_addr    <= w_add_idx[HIST_AW-1:0];
                        r_is_add  <= 1'b1;
                        r_state   <= (w_tenths != '0) ? ST_READ : ST_DONE;
                    end
                end
                ST_READ: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_res_bin <= r_is_add ? w_bin_inc : w_ram_rdata;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_data  <= {2'b00, r_res_bin, r_res_val, r_res_cnt,
                                        r_res_row, r_res_hue};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `HSH_ASSERT_IMPLY(a_div_lockstep, i_clk, i_rst_n, w_hue_done, w_sat_done)
    `HSH_ASSERT_IMPLY(a_div_done_wait, i_clk, i_rst_n, w_hue_done, r_state == ST_DIV_WAIT)
    `HSH_ASSERT_IMPLY(a_ram_write_src, i_clk, i_rst_n, w_ram_we,
        r_state == ST_CLEAR || (r_state == ST_WRITE && r_is_add))
    `HSH_ASSERT_IMPLY(a_counted_in_range, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[13],
        m_axis_tdata[12:9] < ROW_W'(SAT_ROWS) && m_axis_tdata[8:0] < HUE_W'(HUE_BINS))
    `HSH_ASSERT_NEXT(a_clear_reply, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_CLEAR,
        r_state == ST_CLEAR && r_clr_addr == '0)

endmodule
